@@ sv/ssps_pkg.sv @@
// Shared types, fixed-point constants and the rounding helper for the stereo soft clipper.
// Used by the top level and the per-channel datapath; depends on nothing else.
package ssps_pkg;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_INPUT_DRIVE  = 2'd0;
	localparam logic [1:0] REG_OUTPUT_LEVEL = 2'd1;
	localparam logic [1:0] REG_WET_MIX      = 2'd2;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	// Pipeline depth of one channel, first product to saturated result.
	localparam int CHAN_STAGES = 23;

	// Internal widths.
	localparam int DRV_W  = 20;   // input_drive times ten
	localparam int GAIN_W = 30;   // output_level times 9239
	localparam int DRY_W  = 17;   // 32768 - wet_mix, signed
	localparam int X_W    = 31;   // clamped Q4.28 signal
	localparam int X2_W   = 31;   // x squared, Q4.28, never negative
	localparam int B_W    = 32;   // Horner terms
	localparam int YMAG_W = 29;   // polynomial output magnitude
	localparam int PG_W   = 59;   // magnitude times output gain
	localparam int N_W    = 40;   // gained value after the power-of-two part of the divide
	localparam int Q_W    = 31;   // quotient of the divide by 625
	localparam int REM_W  = 11;   // remainder, below three times 625

	// Register defaults and scale factors.
	localparam int DRIVE_RST  = 3277;
	localparam int LEVEL_RST  = 32768;
	localparam int WET_RST    = 32768;
	localparam int FULL_SCALE = 32768;
	localparam int DRIVE_MUL  = 10;
	localparam int OUT_TRIM   = 9239;
	localparam int MIX_SHIFT  = 15;

	// Clamp bound and polynomial coefficients, rounded to nearest.
	localparam longint CLAMP_Q28 = 64'sd618993105;
	localparam longint ONE_Q30   = 64'sd1 <<< 30;
	localparam longint COEF1_Q32 = ((64'sd1 <<< 32) + 3) / 6;
	localparam longint COEF2_Q36 = ((64'sd1 <<< 36) + 34) / 69;
	localparam longint COEF3_Q42 = ((64'sd1 <<< 42) * 100 + 126504) / 253008;
	localparam longint COEF4_Q48 = ((64'sd1 <<< 48) * 10 + 1124928) / 2249856;
	localparam longint COEF5_Q48 = ((64'sd1 <<< 48) + 4989600) / 9979200;

	// Divide by 10000 * 32768 = 2^19 * 625, rounding half away from zero.
	localparam longint HALF_DIV    = 64'sd163840000;
	localparam int     DIV_SHIFT   = 19;
	localparam int     DIV_625     = 625;
	localparam int     DIV_LOW     = 9;
	localparam int     RECIP_SHIFT = 32;
	localparam logic [31:0] RECIP_625 = 32'((64'sd1 <<< (DIV_LOW + RECIP_SHIFT)) / DIV_625);

	// Configuration as the datapath sees it.
	typedef struct packed {
		logic [DRV_W-1:0]        drive10;
		logic [GAIN_W-1:0]       gain;
		logic [CFG_DATA_W-1:0]   wet;
		logic signed [DRY_W-1:0] dry;
	} cfg_t;

	localparam cfg_t CFG_RST = '{
		drive10: DRV_W'(DRIVE_RST * DRIVE_MUL),
		gain:    GAIN_W'(LEVEL_RST * OUT_TRIM),
		wet:     CFG_DATA_W'(WET_RST),
		dry:     DRY_W'(FULL_SCALE - WET_RST)
	};

	// Arithmetic shift right by k >= 1, rounding half away from zero.
	function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v, input int k);
		logic signed [63:0] half;
		logic signed [63:0] t;
		half = 64'sd1 <<< (k - 1);
		t = v + half - 64'(v[63]);
		return t >>> k;
	endfunction

endpackage

@@ sv/ssps_chan.sv @@
// One channel of the soft clipper: drive, clamp, odd polynomial, output gain, mix.
// A 23-stage pipeline, most stages holding one multiplier or one rounding add; uses ssps_pkg.
module ssps_chan #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          en,
	input  ssps_pkg::cfg_t                cfg,
	input  logic signed [SAMPLE_BITS-1:0] smp,
	output logic signed [SAMPLE_BITS-1:0] res
);

	localparam int SW     = SAMPLE_BITS + 3;
	localparam int PW_W   = SW + 17;
	localparam int PD_W   = SAMPLE_BITS + ssps_pkg::DRY_W;
	localparam int DRV_SH = SAMPLE_BITS - 14;
	localparam int DN     = (SAMPLE_BITS < 29) ? 29 - SAMPLE_BITS : 0;
	localparam int UP     = (SAMPLE_BITS > 29) ? SAMPLE_BITS - 29 : 0;
	localparam logic [63:0] HALF_DN = (64'd1 << DN) >> 1;
	localparam longint RES_HI = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint RES_LO = -(64'sd1 <<< (SAMPLE_BITS - 1));

	// Delay lines that keep side values aligned with the main datapath.
	logic signed [SAMPLE_BITS-1:0]       smp_s [1:21];
	logic signed [ssps_pkg::X_W-1:0]     x_s [2:14];
	logic [ssps_pkg::X2_W-1:0]           x2_s [4:12];
	logic                                yneg_s [16:20];

	// Main pipeline registers.
	logic signed [SAMPLE_BITS+20:0]      prod_s1;
	logic signed [63:0]                  xx_s3;
	logic signed [63:0]                  p5_s5;
	logic signed [ssps_pkg::B_W-1:0]     b5_s6;
	logic signed [63:0]                  p7_s7;
	logic signed [ssps_pkg::B_W-1:0]     b4_s8;
	logic signed [63:0]                  p9_s9;
	logic signed [ssps_pkg::B_W-1:0]     b3_s10;
	logic signed [63:0]                  p11_s11;
	logic signed [ssps_pkg::B_W-1:0]     b2_s12;
	logic signed [63:0]                  p13_s13;
	logic signed [ssps_pkg::B_W-1:0]     b1_s14;
	logic signed [63:0]                  p15_s15;
	logic [ssps_pkg::YMAG_W-1:0]         ymag_s16;
	logic [ssps_pkg::PG_W-1:0]           pg_s17;
	logic [ssps_pkg::N_W-1:0]            n_s18;
	logic [ssps_pkg::N_W-1:0]            n_s19;
	logic [ssps_pkg::Q_W-1:0]            q0_s19;
	logic [ssps_pkg::Q_W-1:0]            q0_s20;
	logic [ssps_pkg::REM_W-1:0]          rem_s20;
	logic signed [SW-1:0]                s_s21;
	logic signed [PW_W-1:0]              pw_s22;
	logic signed [PD_W-1:0]              pd_s22;
	logic signed [SAMPLE_BITS-1:0]       res_s23;

	// Next values of the stages that are more than a plain product.
	logic signed [63:0]             x_rnd;
	logic signed [ssps_pkg::X_W-1:0] x_nxt;
	logic signed [63:0]             y_rnd;
	logic [1:0]                     corr;
	logic [ssps_pkg::Q_W:0]         q_fix;
	logic [63:0]                    smag;
	logic signed [SW-1:0]           s_nxt;
	logic signed [63:0]             mix_rnd;
	logic signed [SAMPLE_BITS-1:0]  res_nxt;

	always_comb begin
		// Drive scaling back to Q4.28, then the symmetric clamp.
		x_rnd = ssps_pkg::rnd_shr(64'(prod_s1), DRV_SH);
		if (x_rnd > ssps_pkg::CLAMP_Q28) begin
			x_nxt = ssps_pkg::X_W'(ssps_pkg::CLAMP_Q28);
		end else if (x_rnd < -ssps_pkg::CLAMP_Q28) begin
			x_nxt = ssps_pkg::X_W'(-ssps_pkg::CLAMP_Q28);
		end else begin
			x_nxt = ssps_pkg::X_W'(x_rnd);
		end

		// Polynomial output, split into sign and magnitude for the gain divide.
		y_rnd = ssps_pkg::rnd_shr(p15_s15, 30);

		// The reciprocal estimate is low by at most two; the remainder fixes it.
		if (rem_s20 >= ssps_pkg::REM_W'(2 * ssps_pkg::DIV_625)) begin
			corr = 2'd2;
		end else if (rem_s20 >= ssps_pkg::REM_W'(ssps_pkg::DIV_625)) begin
			corr = 2'd1;
		end else begin
			corr = 2'd0;
		end
		q_fix = {1'b0, q0_s20} + (ssps_pkg::Q_W + 1)'(corr);

		// Move from Q4.28 to the sample format, rounding the magnitude.
		if (DN > 0) begin
			smag = (64'(q_fix) + HALF_DN) >> DN;
		end else begin
			smag = 64'(q_fix) << UP;
		end
		s_nxt = yneg_s[20] ? -SW'(smag) : SW'(smag);

		// Wet and dry sum, back to Q1.x, saturated.
		mix_rnd = ssps_pkg::rnd_shr(64'(pw_s22) + 64'(pd_s22), ssps_pkg::MIX_SHIFT);
		if (mix_rnd > RES_HI) begin
			res_nxt = SAMPLE_BITS'(RES_HI);
		end else if (mix_rnd < RES_LO) begin
			res_nxt = SAMPLE_BITS'(RES_LO);
		end else begin
			res_nxt = SAMPLE_BITS'(mix_rnd);
		end
	end

	// All stages move together when the top level lets the pipeline advance.
	always_ff @(posedge clk) begin
		if (en) begin
			smp_s[1] <= smp;
			for (int k = 2; k <= 21; k++) begin
				smp_s[k] <= smp_s[k-1];
			end
			x_s[2] <= x_nxt;
			for (int k = 3; k <= 14; k++) begin
				x_s[k] <= x_s[k-1];
			end
			x2_s[4] <= ssps_pkg::X2_W'(ssps_pkg::rnd_shr(xx_s3, 28));
			for (int k = 5; k <= 12; k++) begin
				x2_s[k] <= x2_s[k-1];
			end
			yneg_s[16] <= y_rnd[63];
			for (int k = 17; k <= 20; k++) begin
				yneg_s[k] <= yneg_s[k-1];
			end

			// Drive and square.
			prod_s1 <= (SAMPLE_BITS + 21)'(smp) * (SAMPLE_BITS + 21)'({1'b0, cfg.drive10});
			xx_s3   <= 64'(x_s[2]) * 64'(x_s[2]);

			// Horner evaluation in x squared, one product and one rounding add per term.
			p5_s5   <= 64'($signed({1'b0, x2_s[4]})) * ssps_pkg::COEF5_Q48;
			b5_s6   <= ssps_pkg::B_W'(ssps_pkg::COEF4_Q48 - ssps_pkg::rnd_shr(p5_s5, 28));
			p7_s7   <= 64'($signed({1'b0, x2_s[6]})) * 64'(b5_s6);
			b4_s8   <= ssps_pkg::B_W'(ssps_pkg::rnd_shr(p7_s7, 34) - ssps_pkg::COEF3_Q42);
			p9_s9   <= 64'($signed({1'b0, x2_s[8]})) * 64'(b4_s8);
			b3_s10  <= ssps_pkg::B_W'(ssps_pkg::COEF2_Q36 + ssps_pkg::rnd_shr(p9_s9, 34));
			p11_s11 <= 64'($signed({1'b0, x2_s[10]})) * 64'(b3_s10);
			b2_s12  <= ssps_pkg::B_W'(ssps_pkg::rnd_shr(p11_s11, 32) - ssps_pkg::COEF1_Q32);
			p13_s13 <= 64'($signed({1'b0, x2_s[12]})) * 64'(b2_s12);
			b1_s14  <= ssps_pkg::B_W'(ssps_pkg::ONE_Q30 + ssps_pkg::rnd_shr(p13_s13, 30));
			p15_s15 <= 64'(x_s[14]) * 64'(b1_s14);
			ymag_s16 <= ssps_pkg::YMAG_W'(y_rnd[63] ? -y_rnd : y_rnd);

			// Output gain: magnitude times level times 9239, divided by 2^19 then by 625.
			pg_s17 <= ssps_pkg::PG_W'(64'(ymag_s16) * 64'(cfg.gain));
			n_s18  <= ssps_pkg::N_W'((64'(pg_s17) + ssps_pkg::HALF_DIV) >> ssps_pkg::DIV_SHIFT);
			n_s19  <= n_s18;
			q0_s19 <= ssps_pkg::Q_W'((64'(n_s18[ssps_pkg::N_W-1:ssps_pkg::DIV_LOW])
				* 64'(ssps_pkg::RECIP_625)) >> ssps_pkg::RECIP_SHIFT);
			q0_s20  <= q0_s19;
			rem_s20 <= ssps_pkg::REM_W'(n_s19
				- ssps_pkg::N_W'(q0_s19) * ssps_pkg::N_W'(ssps_pkg::DIV_625));
			s_s21 <= s_nxt;

			// Mix products and the saturated result.
			pw_s22  <= PW_W'(64'(s_s21) * 64'($signed({1'b0, cfg.wet})));
			pd_s22  <= PD_W'(64'(smp_s[21]) * 64'(cfg.dry));
			res_s23 <= res_nxt;
		end
	end

	assign res = res_s23;

endmodule

@@ sv/stereo_sine_poly_saturator.sv @@
// Top level of the stereo soft clipper: configuration registers, valid pipeline,
// output register with skid stage, and two ssps_chan datapaths; uses ssps_pkg.
//
//   channel   handshake               payload
//   input     in_valid / in_ready     left_sample, right_sample
//   output    out_valid / out_ready   left_result, right_result
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One stereo word enters per cycle while in_ready is high, through the 23-stage channel pipeline.
// An accepted word passes through the channel pipeline and, when the output is free, into the output register.
// A stalled output word is held; one more word lands in the skid stage, after which
// in_ready drops and the pipeline freezes until the output word is taken.
// Reset clears all valid bits and loads the register defaults; cfg_ready is always high.
module stereo_sine_poly_saturator #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [SAMPLE_BITS-1:0]        left_sample,
	input  logic signed [SAMPLE_BITS-1:0]        right_sample,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [SAMPLE_BITS-1:0]        left_result,
	output logic signed [SAMPLE_BITS-1:0]        right_result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ssps_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [ssps_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int NS = ssps_pkg::CHAN_STAGES;

	ssps_pkg::cfg_t                cfg_q;
	logic                          vld_s [1:NS];
	logic                          en;
	logic                          push;
	logic                          take;
	logic signed [SAMPLE_BITS-1:0] left_res;
	logic signed [SAMPLE_BITS-1:0] right_res;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_left_q;
	logic signed [SAMPLE_BITS-1:0] out_right_q;
	logic                          sk_valid_q;
	logic signed [SAMPLE_BITS-1:0] sk_left_q;
	logic signed [SAMPLE_BITS-1:0] sk_right_q;

	// Configuration registers, stored in the scaled form the datapath uses.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= ssps_pkg::CFG_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ssps_pkg::REG_INPUT_DRIVE: begin
					cfg_q.drive10 <= ssps_pkg::DRV_W'(cfg_data)
						* ssps_pkg::DRV_W'(ssps_pkg::DRIVE_MUL);
				end
				ssps_pkg::REG_OUTPUT_LEVEL: begin
					cfg_q.gain <= ssps_pkg::GAIN_W'(cfg_data)
						* ssps_pkg::GAIN_W'(ssps_pkg::OUT_TRIM);
				end
				ssps_pkg::REG_WET_MIX: begin
					cfg_q.wet <= cfg_data;
					cfg_q.dry <= ssps_pkg::DRY_W'(ssps_pkg::FULL_SCALE)
						- ssps_pkg::DRY_W'(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	// The pipeline advances whenever the skid stage is empty.
	assign en       = !sk_valid_q;
	assign in_ready = en;
	assign push     = en && vld_s[NS];
	assign take     = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NS; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[1] <= in_valid;
			for (int k = 2; k <= NS; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	ssps_chan #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_left (
		.clk(clk),
		.en (en),
		.cfg(cfg_q),
		.smp(left_sample),
		.res(left_res)
	);

	ssps_chan #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_right (
		.clk(clk),
		.en (en),
		.cfg(cfg_q),
		.smp(right_sample),
		.res(right_res)
	);

	// Output register and skid stage: control bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sk_valid_q  <= 1'b0;
		end else if (sk_valid_q) begin
			if (take) begin
				sk_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				sk_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register and skid stage: word data.
	always_ff @(posedge clk) begin
		if (sk_valid_q) begin
			if (take) begin
				out_left_q  <= sk_left_q;
				out_right_q <= sk_right_q;
			end
		end else if (push) begin
			if (!out_valid_q || take) begin
				out_left_q  <= left_res;
				out_right_q <= right_res;
			end else begin
				sk_left_q  <= left_res;
				sk_right_q <= right_res;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign left_result  = out_left_q;
	assign right_result = out_right_q;

endmodule

@@ sv/ssps_checker.sv @@
// Port-level checks for the stereo soft clipper, bound to the top level.
// Depends only on the top level's ports.
module ssps_checker #(
	parameter int SAMPLE_BITS = 24
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [SAMPLE_BITS-1:0] left_result,
	input logic signed [SAMPLE_BITS-1:0] right_result
);

	// A stalled output word stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_result) && $stable(right_result))
		else $error("output word changed or vanished while stalled");

	// Input back-pressure only happens behind a waiting output word.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("in_ready low with no output word waiting");

	// in_ready drops only after the output was stalled.
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(out_valid && !out_ready))
		else $error("in_ready fell without an output stall");

	// Once the waiting word is taken, input opens again.
	a_ready_back: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && out_ready |=> in_ready)
		else $error("in_ready stayed low after the output word was taken");

	// No word can be on the output right out of reset.
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid directly after reset");

endmodule

bind stereo_sine_poly_saturator ssps_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_ssps_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.left_result (left_result),
	.right_result(right_result)
);
